@@ rtl/core/imgrot_pkg.sv @@
package imgrot_pkg;

    // Field widths
    localparam int PIX_W      = 8;
    localparam int COORD_W    = 9;
    localparam int SRC_POS_W  = 8;
    localparam int TRIG_W     = 16;
    localparam int SIZE_W     = 9;
    localparam int WORD_W     = 4 * PIX_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Parameter defaults
    localparam int MAX_ROWS_DEF  = 256;
    localparam int MAX_COLS_DEF  = 256;
    localparam int FRAC_BITS_DEF = 14;

    // Datapath widths: the multiplier takes a 26-bit signed operand
    // (box minimum, coordinate or size) against a 16-bit trig value
    localparam int MUL_A_W = 26;
    localparam int PROD_W  = MUL_A_W + TRIG_W;
    localparam int SPAN_W  = 26;
    localparam int L_W     = PROD_W + 1;
    localparam int H_W     = 27;

    localparam int MUL_STEPS = 12;
    localparam int STEP_W    = 4;

    localparam logic [PIX_W-1:0]  PIX_FULL  = 8'hFF;
    localparam logic [PIX_W-1:0]  PIX_NONE  = 8'h00;
    localparam logic [SIZE_W-1:0] SIZE_SAT  = 9'd511;

    // Request codes
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_FETCH = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd3;

    localparam logic signed [TRIG_W-1:0] COS_RESET  = 16'sd16384;
    localparam logic signed [TRIG_W-1:0] SIN_RESET  = 16'sd0;
    localparam logic [SIZE_W-1:0]        ROWS_RESET = 9'd256;
    localparam logic [SIZE_W-1:0]        COLS_RESET = 9'd256;

    typedef struct packed {
        logic signed [TRIG_W-1:0] cos_q;
        logic signed [TRIG_W-1:0] sin_q;
        logic [SIZE_W-1:0]        src_rows;
        logic [SIZE_W-1:0]        src_cols;
    } cfg_t;

    typedef enum logic [2:0] {
        A_NR1,
        A_NC1,
        A_RMIN,
        A_CMIN,
        A_OROW,
        A_OCOL
    } a_sel_t;

    typedef enum logic {
        B_COS,
        B_SIN
    } b_sel_t;

    typedef enum logic [2:0] {
        D_NONE,
        D_BOX_R,
        D_BOX_C,
        D_L_R,
        D_L_C,
        D_H_R,
        D_H_C
    } dst_t;

    typedef struct packed {
        logic   wr_en;
        logic   capture;
        a_sel_t a_sel;
        b_sel_t b_sel;
        dst_t   dst;
        logic   clr;
        logic   neg;
        logic   sum_en;
        logic   map_en;
        logic   rd_en;
        logic   out_ld;
    } dp_cmd_t;

endpackage

@@ rtl/core/imgrot_if.sv @@
interface imgrot_req_if;
    logic                             valid;
    logic                             ready;
    logic                             req_type;
    logic [imgrot_pkg::SRC_POS_W-1:0] src_row;
    logic [imgrot_pkg::SRC_POS_W-1:0] src_col;
    logic [imgrot_pkg::PIX_W-1:0]     pix_r;
    logic [imgrot_pkg::PIX_W-1:0]     pix_g;
    logic [imgrot_pkg::PIX_W-1:0]     pix_b;
    logic [imgrot_pkg::PIX_W-1:0]     pix_alpha;
    logic [imgrot_pkg::COORD_W-1:0]   out_row;
    logic [imgrot_pkg::COORD_W-1:0]   out_col;

    modport source (
        output valid, req_type, src_row, src_col, pix_r, pix_g, pix_b, pix_alpha,
               out_row, out_col,
        input  ready
    );

    modport sink (
        input  valid, req_type, src_row, src_col, pix_r, pix_g, pix_b, pix_alpha,
               out_row, out_col,
        output ready
    );
endinterface

interface imgrot_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [imgrot_pkg::PIX_W-1:0]  red;
    logic [imgrot_pkg::PIX_W-1:0]  green;
    logic [imgrot_pkg::PIX_W-1:0]  blue;
    logic [imgrot_pkg::PIX_W-1:0]  alpha;
    logic                          in_source;
    logic [imgrot_pkg::SIZE_W-1:0] rotated_rows;
    logic [imgrot_pkg::SIZE_W-1:0] rotated_cols;

    modport source (
        output valid, red, green, blue, alpha, in_source, rotated_rows, rotated_cols,
        input  ready
    );

    modport sink (
        input  valid, red, green, blue, alpha, in_source, rotated_rows, rotated_cols,
        output ready
    );
endinterface

@@ rtl/core/image_rotate_nearest.sv @@
// Channel  | Role | Handshake     | Carries
// ---------+------+---------------+-----------------------------------------------
// req      | sink | valid / ready | req_type, source pixel load or rotated fetch
// rsp      | src  | valid / ready | rotated pixel, in_source flag, rotated size
// cfg      | sink | cfg_we only   | cos_q, sin_q, src_rows, src_cols by cfg_idx
//
// A load writes the source store when accepted; loads stream at one per cycle when idle.
// A fetch item runs twelve products on one shared 26x16 multiplier, then accumulate, sum,
// map, store read and output load. The result can leave at the next edge, where the next
// item can also be accepted.
// The store has no reset; entries hold garbage until loaded. Reset clears control
// state and loads the default configuration (unit cosine, 256 x 256 source).
// A stalled result holds in the output register; the next load is accepted meanwhile,
// and a following fetch runs up to its output load before it waits.
module image_rotate_nearest #(
    parameter int MAX_ROWS  = imgrot_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS  = imgrot_pkg::MAX_COLS_DEF,
    parameter int FRAC_BITS = imgrot_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    imgrot_req_if.sink                          req,
    imgrot_rsp_if.source                        rsp,
    input  logic                                cfg_we,
    input  logic [imgrot_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [imgrot_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    imgrot_pkg::cfg_t    cfg_reg;
    imgrot_pkg::dp_cmd_t cmd;

    // Configuration registers; user must write only while the block is idle, unenforced
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cos_q    <= imgrot_pkg::COS_RESET;
            cfg_reg.sin_q    <= imgrot_pkg::SIN_RESET;
            cfg_reg.src_rows <= imgrot_pkg::ROWS_RESET;
            cfg_reg.src_cols <= imgrot_pkg::COLS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                imgrot_pkg::CFG_COS:  cfg_reg.cos_q    <= $signed(cfg_wdata);
                imgrot_pkg::CFG_SIN:  cfg_reg.sin_q    <= $signed(cfg_wdata);
                imgrot_pkg::CFG_ROWS: cfg_reg.src_rows <= cfg_wdata[imgrot_pkg::SIZE_W-1:0];
                imgrot_pkg::CFG_COLS: cfg_reg.src_cols <= cfg_wdata[imgrot_pkg::SIZE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Sequencer: accepts items, steps the multiply schedule, owns the result valid
    imgrot_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (req.valid),
        .in_req_type (req.req_type),
        .in_ready    (req.ready),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .cmd         (cmd)
    );

    // Arithmetic, source store and result payload
    imgrot_dp #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk          (clk),
        .cfg          (cfg_reg),
        .cmd          (cmd),
        .src_row      (req.src_row),
        .src_col      (req.src_col),
        .pix_r        (req.pix_r),
        .pix_g        (req.pix_g),
        .pix_b        (req.pix_b),
        .pix_alpha    (req.pix_alpha),
        .out_row      (req.out_row),
        .out_col      (req.out_col),
        .red          (rsp.red),
        .green        (rsp.green),
        .blue         (rsp.blue),
        .alpha        (rsp.alpha),
        .in_source    (rsp.in_source),
        .rotated_rows (rsp.rotated_rows),
        .rotated_cols (rsp.rotated_cols)
    );

endmodule

@@ rtl/core/imgrot_ctrl.sv @@
module imgrot_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_req_type,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output imgrot_pkg::dp_cmd_t cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MUL   = 7'b0000010,
        S_DRAIN = 7'b0000100,
        S_SUM   = 7'b0001000,
        S_MAP   = 7'b0010000,
        S_READ  = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    typedef struct packed {
        imgrot_pkg::a_sel_t a_sel;
        imgrot_pkg::b_sel_t b_sel;
        imgrot_pkg::dst_t   dst;
        logic               clr;
        logic               neg;
    } step_t;

    // Product schedule: box corners, box offset terms, then the output coordinate terms
    function automatic step_t step_entry(input logic [imgrot_pkg::STEP_W-1:0] idx);
        step_t e;
        e = '{imgrot_pkg::A_NR1, imgrot_pkg::B_COS, imgrot_pkg::D_NONE, 1'b0, 1'b0};
        case (idx)
            4'd0:    e = '{imgrot_pkg::A_NR1,  imgrot_pkg::B_COS, imgrot_pkg::D_BOX_R, 1'b1, 1'b0};
            4'd1:    e = '{imgrot_pkg::A_NC1,  imgrot_pkg::B_SIN, imgrot_pkg::D_BOX_R, 1'b0, 1'b0};
            4'd2:    e = '{imgrot_pkg::A_NC1,  imgrot_pkg::B_COS, imgrot_pkg::D_BOX_C, 1'b1, 1'b0};
            4'd3:    e = '{imgrot_pkg::A_NR1,  imgrot_pkg::B_SIN, imgrot_pkg::D_BOX_C, 1'b0, 1'b1};
            4'd4:    e = '{imgrot_pkg::A_RMIN, imgrot_pkg::B_COS, imgrot_pkg::D_L_R,   1'b1, 1'b0};
            4'd5:    e = '{imgrot_pkg::A_CMIN, imgrot_pkg::B_SIN, imgrot_pkg::D_L_R,   1'b0, 1'b1};
            4'd6:    e = '{imgrot_pkg::A_RMIN, imgrot_pkg::B_SIN, imgrot_pkg::D_L_C,   1'b1, 1'b0};
            4'd7:    e = '{imgrot_pkg::A_CMIN, imgrot_pkg::B_COS, imgrot_pkg::D_L_C,   1'b0, 1'b0};
            4'd8:    e = '{imgrot_pkg::A_OROW, imgrot_pkg::B_COS, imgrot_pkg::D_H_R,   1'b1, 1'b0};
            4'd9:    e = '{imgrot_pkg::A_OCOL, imgrot_pkg::B_SIN, imgrot_pkg::D_H_R,   1'b0, 1'b1};
            4'd10:   e = '{imgrot_pkg::A_OROW, imgrot_pkg::B_SIN, imgrot_pkg::D_H_C,   1'b1, 1'b0};
            4'd11:   e = '{imgrot_pkg::A_OCOL, imgrot_pkg::B_COS, imgrot_pkg::D_H_C,   1'b0, 1'b0};
            default: e = '{imgrot_pkg::A_NR1,  imgrot_pkg::B_COS, imgrot_pkg::D_NONE,  1'b0, 1'b0};
        endcase
        return e;
    endfunction

    localparam logic [imgrot_pkg::STEP_W-1:0] LAST_STEP =
        imgrot_pkg::STEP_W'(imgrot_pkg::MUL_STEPS - 1);

    state_t                          state_reg, state_next;
    logic [imgrot_pkg::STEP_W-1:0]   step_reg, step_next;
    imgrot_pkg::dst_t                acc_dst_reg, acc_dst_next;
    logic                            acc_clr_reg, acc_clr_next;
    logic                            acc_neg_reg, acc_neg_next;
    logic                            out_valid_reg, out_valid_next;
    step_t                           cur;
    logic                            accept;
    logic                            slot_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign cur       = step_entry(step_reg);

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        acc_dst_next   = imgrot_pkg::D_NONE;
        acc_clr_next   = 1'b0;
        acc_neg_next   = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;

        cmd         = '0;
        cmd.a_sel   = cur.a_sel;
        cmd.b_sel   = cur.b_sel;
        cmd.dst     = acc_dst_reg;
        cmd.clr     = acc_clr_reg;
        cmd.neg     = acc_neg_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_req_type == imgrot_pkg::REQ_FETCH)
                    begin
                        cmd.capture = 1'b1;
                        step_next   = '0;
                        state_next  = S_MUL;
                    end
                    else
                    begin
                        cmd.wr_en = 1'b1;
                    end
                end
            end
            S_MUL:
            begin
                // queue this product's accumulate for the cycle after
                acc_dst_next = cur.dst;
                acc_clr_next = cur.clr;
                acc_neg_next = cur.neg;
                step_next    = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum_en = 1'b1;
                state_next = S_MAP;
            end
            S_MAP:
            begin
                cmd.map_en = 1'b1;
                state_next = S_READ;
            end
            S_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    cmd.out_ld     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            acc_dst_reg   <= imgrot_pkg::D_NONE;
            acc_clr_reg   <= 1'b0;
            acc_neg_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            acc_dst_reg   <= acc_dst_next;
            acc_clr_reg   <= acc_clr_next;
            acc_neg_reg   <= acc_neg_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ rtl/core/imgrot_dp.sv @@
module imgrot_dp #(
    parameter int MAX_ROWS  = imgrot_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS  = imgrot_pkg::MAX_COLS_DEF,
    parameter int FRAC_BITS = imgrot_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  imgrot_pkg::cfg_t                   cfg,
    input  imgrot_pkg::dp_cmd_t                cmd,
    input  logic [imgrot_pkg::SRC_POS_W-1:0]   src_row,
    input  logic [imgrot_pkg::SRC_POS_W-1:0]   src_col,
    input  logic [imgrot_pkg::PIX_W-1:0]       pix_r,
    input  logic [imgrot_pkg::PIX_W-1:0]       pix_g,
    input  logic [imgrot_pkg::PIX_W-1:0]       pix_b,
    input  logic [imgrot_pkg::PIX_W-1:0]       pix_alpha,
    input  logic [imgrot_pkg::COORD_W-1:0]     out_row,
    input  logic [imgrot_pkg::COORD_W-1:0]     out_col,
    output logic [imgrot_pkg::PIX_W-1:0]       red,
    output logic [imgrot_pkg::PIX_W-1:0]       green,
    output logic [imgrot_pkg::PIX_W-1:0]       blue,
    output logic [imgrot_pkg::PIX_W-1:0]       alpha,
    output logic                               in_source,
    output logic [imgrot_pkg::SIZE_W-1:0]      rotated_rows,
    output logic [imgrot_pkg::SIZE_W-1:0]      rotated_cols
);

    localparam int RW        = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW        = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int AW        = RW + CW;
    localparam int MEM_DEPTH = 2 ** AW;
    localparam int SIZE_W    = imgrot_pkg::SIZE_W;
    localparam int MUL_A_W   = imgrot_pkg::MUL_A_W;
    localparam int PROD_W    = imgrot_pkg::PROD_W;
    localparam int SPAN_W    = imgrot_pkg::SPAN_W;
    localparam int L_W       = imgrot_pkg::L_W;
    localparam int H_W       = imgrot_pkg::H_W;
    localparam int PIX_W     = imgrot_pkg::PIX_W;
    localparam int WORD_W    = imgrot_pkg::WORD_W;
    // Q(2F) sum of the coordinate and offset terms, plus headroom for the round-up add
    localparam int NUM_A     = H_W + FRAC_BITS + 1;
    localparam int NUM_B     = (NUM_A > L_W + 1) ? NUM_A : L_W + 1;
    localparam int NUM_W     = ((NUM_B > 2 * FRAC_BITS + 1) ? NUM_B : 2 * FRAC_BITS + 1) + 1;
    localparam int SQ_W      = SPAN_W + FRAC_BITS + 1;

    localparam logic signed [NUM_W-1:0] NUM_RND =
        (NUM_W'(1) <<< (2 * FRAC_BITS)) - NUM_W'(1);
    localparam logic [SQ_W-1:0] SPAN_RND = (SQ_W'(1) << FRAC_BITS) - SQ_W'(1);

    logic [WORD_W-1:0] mem [MEM_DEPTH];

    logic [SIZE_W-1:0]               nr, nc, nr1, nc1;
    logic [imgrot_pkg::COORD_W-1:0]  orow_in_reg, ocol_in_reg;
    logic signed [MUL_A_W-1:0]       mul_a;
    logic signed [imgrot_pkg::TRIG_W-1:0] mul_b;
    logic signed [PROD_W-1:0]        prod_reg;
    logic signed [PROD_W-1:0]        acc_v;
    logic signed [SPAN_W-1:0]        box_v, box_min, box_abs;
    logic signed [SPAN_W-1:0]        rmin_reg, cmin_reg, rspan_reg, cspan_reg;
    logic signed [L_W-1:0]           lrow_reg, lcol_reg;
    logic signed [H_W-1:0]           hrow_reg, hcol_reg;
    logic signed [NUM_W-1:0]         nrow_reg, ncol_reg;
    logic signed [NUM_W-1:0]         orow, ocol;
    logic [SQ_W-1:0]                 rq, cq;
    logic [AW-1:0]                   rd_addr_reg;
    logic                            inside_reg;
    logic [SIZE_W-1:0]               rows_reg, cols_reg;
    logic [WORD_W-1:0]               rd_data_reg;
    logic                            wr_ok;
    logic [RW-1:0]                   wr_row;
    logic [CW-1:0]                   wr_col;

    // Clamp the used source size to [1, MAX]
    always_comb
    begin
        nr = (cfg.src_rows == '0) ? SIZE_W'(1) : cfg.src_rows;
        if (int'(nr) > MAX_ROWS)
        begin
            nr = SIZE_W'(MAX_ROWS);
        end
        nc = (cfg.src_cols == '0) ? SIZE_W'(1) : cfg.src_cols;
        if (int'(nc) > MAX_COLS)
        begin
            nc = SIZE_W'(MAX_COLS);
        end
        nr1 = nr - 1'b1;
        nc1 = nc - 1'b1;
    end

    // Shared multiplier operands
    always_comb
    begin
        case (cmd.a_sel)
            imgrot_pkg::A_NR1:  mul_a = $signed(MUL_A_W'(nr1));
            imgrot_pkg::A_NC1:  mul_a = $signed(MUL_A_W'(nc1));
            imgrot_pkg::A_RMIN: mul_a = rmin_reg;
            imgrot_pkg::A_CMIN: mul_a = cmin_reg;
            imgrot_pkg::A_OROW: mul_a = $signed(MUL_A_W'(orow_in_reg));
            imgrot_pkg::A_OCOL: mul_a = $signed(MUL_A_W'(ocol_in_reg));
            default:            mul_a = '0;
        endcase
        case (cmd.b_sel)
            imgrot_pkg::B_COS: mul_b = cfg.cos_q;
            imgrot_pkg::B_SIN: mul_b = cfg.sin_q;
            default:           mul_b = cfg.cos_q;
        endcase
    end

    always_comb
    begin
        acc_v   = cmd.neg ? -prod_reg : prod_reg;
        box_v   = acc_v[SPAN_W-1:0];
        box_min = (box_v < 0) ? box_v : '0;
        box_abs = (box_v < 0) ? -box_v : box_v;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (cmd.capture)
        begin
            orow_in_reg <= out_row;
            ocol_in_reg <= out_col;
        end
        // Box: min over {0, x, y, x+y} is min(0,x)+min(0,y); span is |x|+|y|
        case (cmd.dst)
            imgrot_pkg::D_BOX_R:
            begin
                rmin_reg  <= (cmd.clr ? '0 : rmin_reg) + box_min;
                rspan_reg <= (cmd.clr ? '0 : rspan_reg) + box_abs;
            end
            imgrot_pkg::D_BOX_C:
            begin
                cmin_reg  <= (cmd.clr ? '0 : cmin_reg) + box_min;
                cspan_reg <= (cmd.clr ? '0 : cspan_reg) + box_abs;
            end
            imgrot_pkg::D_L_R: lrow_reg <= (cmd.clr ? '0 : lrow_reg) + L_W'(acc_v);
            imgrot_pkg::D_L_C: lcol_reg <= (cmd.clr ? '0 : lcol_reg) + L_W'(acc_v);
            imgrot_pkg::D_H_R: hrow_reg <= (cmd.clr ? '0 : hrow_reg) + acc_v[H_W-1:0];
            imgrot_pkg::D_H_C: hcol_reg <= (cmd.clr ? '0 : hcol_reg) + acc_v[H_W-1:0];
            default:
            begin
            end
        endcase
        if (cmd.sum_en)
        begin
            nrow_reg <= (NUM_W'(hrow_reg) <<< FRAC_BITS) + NUM_W'(lrow_reg) + NUM_RND;
            ncol_reg <= (NUM_W'(hcol_reg) <<< FRAC_BITS) + NUM_W'(lcol_reg) + NUM_RND;
        end
    end

    // Round up: floor((v + 2^s - 1) / 2^s)
    always_comb
    begin
        orow = nrow_reg >>> (2 * FRAC_BITS);
        ocol = ncol_reg >>> (2 * FRAC_BITS);
        rq   = (SQ_W'($unsigned(rspan_reg)) + SPAN_RND) >> FRAC_BITS;
        cq   = (SQ_W'($unsigned(cspan_reg)) + SPAN_RND) >> FRAC_BITS;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.map_en)
        begin
            inside_reg  <= (orow >= 0) && (orow < $signed(NUM_W'(nr)))
                        && (ocol >= 0) && (ocol < $signed(NUM_W'(nc)));
            rd_addr_reg <= {orow[RW-1:0], ocol[CW-1:0]};
            rows_reg    <= (rq > SQ_W'(imgrot_pkg::SIZE_SAT)) ? imgrot_pkg::SIZE_SAT
                                                               : rq[SIZE_W-1:0];
            cols_reg    <= (cq > SQ_W'(imgrot_pkg::SIZE_SAT)) ? imgrot_pkg::SIZE_SAT
                                                               : cq[SIZE_W-1:0];
        end
    end

    // Source store
    assign wr_ok  = (int'(src_row) < MAX_ROWS) && (int'(src_col) < MAX_COLS);
    assign wr_row = RW'(src_row);
    assign wr_col = CW'(src_col);

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && wr_ok)
        begin
            mem[{wr_row, wr_col}] <= {pix_alpha, pix_b, pix_g, pix_r};
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr_reg];
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_ld)
        begin
            in_source    <= inside_reg;
            rotated_rows <= rows_reg;
            rotated_cols <= cols_reg;
            if (inside_reg)
            begin
                red   <= rd_data_reg[PIX_W-1:0];
                green <= rd_data_reg[2*PIX_W-1:PIX_W];
                blue  <= rd_data_reg[3*PIX_W-1:2*PIX_W];
                alpha <= rd_data_reg[4*PIX_W-1:3*PIX_W];
            end
            else
            begin
                red   <= imgrot_pkg::PIX_FULL;
                green <= imgrot_pkg::PIX_FULL;
                blue  <= imgrot_pkg::PIX_FULL;
                alpha <= imgrot_pkg::PIX_NONE;
            end
        end
    end

endmodule

@@ tb/sv/image_rotate_nearest_tb.sv @@
module image_rotate_nearest_tb;
    import imgrot_pkg::*;

    // Leave a margin on top of the fetch latency.
    localparam int SETTLE_CYCLES = 30;
    localparam int TAIL_CYCLES   = 40;
    localparam int CYCLE_LIMIT   = 900000;
    localparam int ITEM_TARGET   = 1800;
    localparam int MAX_REPORTS   = 10;
    localparam int STORE_DEPTH   = MAX_ROWS_DEF * MAX_COLS_DEF;

    // One entry of the send plan: a request item, a register write, or a
    // pause that waits until every fetched pixel has come back.
    typedef enum logic [1:0] {
        STEP_ITEM,
        STEP_REG,
        STEP_DRAIN
    } step_kind_t;

    typedef struct packed {
        step_kind_t             kind;
        logic                   req_type;
        logic [SRC_POS_W-1:0]   src_row;
        logic [SRC_POS_W-1:0]   src_col;
        logic [WORD_W-1:0]      pixel;      // {alpha, blue, green, red}
        logic [COORD_W-1:0]     out_row;
        logic [COORD_W-1:0]     out_col;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
    } step_t;

    typedef struct packed {
        logic [PIX_W-1:0]  red;
        logic [PIX_W-1:0]  green;
        logic [PIX_W-1:0]  blue;
        logic [PIX_W-1:0]  alpha;
        logic              in_source;
        logic [SIZE_W-1:0] rotated_rows;
        logic [SIZE_W-1:0] rotated_cols;
    } rot_pixel_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    imgrot_req_if req_bus ();
    imgrot_rsp_if rsp_bus ();

    image_rotate_nearest DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_bus),
        .rsp       (rsp_bus),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    // Send plan, filled up front and consumed by the driver.
    step_t             request_plan[$];
    // Rotated pixels predicted for accepted fetches, oldest first.
    rot_pixel_t        pixels_due[$];

    // Predictor state, advanced on accepted items and driven writes.
    cfg_t              model_cfg;
    logic [WORD_W-1:0] source_image [0:STORE_DEPTH-1];

    // Planning state: settings and loaded entries as the plan will leave them.
    cfg_t              gen_cfg;
    bit                gen_written [0:STORE_DEPTH-1];

    int  item_count   = 0;
    int  fail_count   = 0;
    int  cycle_count  = 0;
    int  gap_left     = 0;
    int  ready_left   = 0;
    int  settle_count = 0;
    bit  idling_on    = 1'b1;
    bit  req_taken    = 1'b0;

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Arithmetic of the rotation, in wide signed integers
    // ------------------------------------------------------------------

    // Clamp a size register to the store bounds.
    function automatic longint size_in_use(logic [SIZE_W-1:0] v, int hi);
        longint n;
        n = longint'(v);
        if (n < 1)
            n = 1;
        if (n > hi)
            n = hi;
        return n;
    endfunction

    // Exact ceil(v / 2^sh) for either sign.
    function automatic longint ceil_pow2(longint v, int sh);
        if (v >= 0)
            return (v + (longint'(1) << sh) - 1) >>> sh;
        return -((-v) >>> sh);
    endfunction

    // Saturate a box size to the output field.
    function automatic logic [SIZE_W-1:0] clip_size(longint v);
        if (v < 0)
            return '0;
        if (v > longint'(SIZE_SAT))
            return SIZE_SAT;
        return v[SIZE_W-1:0];
    endfunction

    // Map an output coordinate back into the source image. Also return the
    // size of the rotated bounding box, which every fetch reports.
    function automatic void back_map(input cfg_t c,
                                     input logic [COORD_W-1:0] orow,
                                     input logic [COORD_W-1:0] ocol,
                                     output longint srow,
                                     output longint scol,
                                     output logic in_src,
                                     output logic [SIZE_W-1:0] box_rows,
                                     output logic [SIZE_W-1:0] box_cols);
        longint cs, sn, nr, nc, kr, kc, a, b;
        longint rmin, rmax, cmin, cmax, pr, pc;
        cs = c.cos_q;
        sn = c.sin_q;
        nr = size_in_use(c.src_rows, MAX_ROWS_DEF);
        nc = size_in_use(c.src_cols, MAX_COLS_DEF);
        // The box extremes start at zero, not at the first corner.
        rmin = 0;
        rmax = 0;
        cmin = 0;
        cmax = 0;
        for (int k = 0; k < 4; k++)
        begin
            kr = (k >= 2) ? nr - 1 : 0;
            kc = (k % 2 == 1) ? nc - 1 : 0;
            a  = kr * cs + kc * sn;
            b  = kc * cs - kr * sn;
            if (a < rmin) rmin = a;
            if (a > rmax) rmax = a;
            if (b < cmin) cmin = b;
            if (b > cmax) cmax = b;
        end
        box_rows = clip_size(ceil_pow2(rmax - rmin, FRAC_BITS_DEF));
        box_cols = clip_size(ceil_pow2(cmax - cmin, FRAC_BITS_DEF));
        // Shift the request by the box minimum, rotate back, round up.
        pr = longint'(orow) * (longint'(1) << FRAC_BITS_DEF) + rmin;
        pc = longint'(ocol) * (longint'(1) << FRAC_BITS_DEF) + cmin;
        srow = ceil_pow2(pr * cs - pc * sn, 2 * FRAC_BITS_DEF);
        scol = ceil_pow2(pr * sn + pc * cs, 2 * FRAC_BITS_DEF);
        in_src = (srow >= 0) && (srow < nr) && (scol >= 0) && (scol < nc);
    endfunction

    // Idle length for either side: mostly none, some short, a few long.
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (!idling_on || roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // Plan building
    // ------------------------------------------------------------------

    task automatic push_load(logic [SRC_POS_W-1:0] r, logic [SRC_POS_W-1:0] c,
                             logic [WORD_W-1:0] px);
        step_t s;
        s          = '0;
        s.kind     = STEP_ITEM;
        s.req_type = REQ_LOAD;
        s.src_row  = r;
        s.src_col  = c;
        s.pixel    = px;
        request_plan.push_back(s);
        gen_written[{r, c}] = 1'b1;
        item_count++;
    endtask

    task automatic push_drain();
        step_t s;
        s      = '0;
        s.kind = STEP_DRAIN;
        request_plan.push_back(s);
    endtask

    task automatic push_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        step_t s;
        s         = '0;
        s.kind    = STEP_REG;
        s.reg_idx = idx;
        s.reg_val = val;
        request_plan.push_back(s);
    endtask

    // Write all four registers once the block has gone quiet.
    task automatic reconfigure(int cq, int sq, int nr, int nc);
        push_drain();
        push_reg(CFG_COS, CFG_DATA_W'(cq));
        push_reg(CFG_SIN, CFG_DATA_W'(sq));
        push_reg(CFG_ROWS, CFG_DATA_W'(nr & 'h1FF));
        push_reg(CFG_COLS, CFG_DATA_W'(nc & 'h1FF));
        gen_cfg.cos_q    = TRIG_W'(cq);
        gen_cfg.sin_q    = TRIG_W'(sq);
        gen_cfg.src_rows = SIZE_W'(nr);
        gen_cfg.src_cols = SIZE_W'(nc);
    endtask

    // Add a fetch in the given window, but never one that lands on a store
    // entry not yet loaded. Give up after a few draws.
    task automatic try_fetch(int r_lo, int r_hi, int c_lo, int c_hi, output bit sent);
        step_t              s;
        logic [COORD_W-1:0] orow, ocol;
        longint             sr, sc;
        logic               in_src;
        logic [SIZE_W-1:0]  br, bc;
        sent = 1'b0;
        for (int t = 0; t < 16 && !sent; t++)
        begin
            orow = COORD_W'($urandom_range(r_lo, r_hi));
            ocol = COORD_W'($urandom_range(c_lo, c_hi));
            back_map(gen_cfg, orow, ocol, sr, sc, in_src, br, bc);
            if (!in_src || gen_written[int'(sr) * MAX_COLS_DEF + int'(sc)])
            begin
                s          = '0;
                s.kind     = STEP_ITEM;
                s.req_type = REQ_FETCH;
                s.out_row  = orow;
                s.out_col  = ocol;
                request_plan.push_back(s);
                item_count++;
                sent = 1'b1;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int                mode, quarter, steps, sel, nr, nc, rows_v, cols_v, cq, sq;
        real               theta, cr, sr_r;
        bit                sent;
        longint            sr, sc;
        logic              in_src;
        logic [SIZE_W-1:0] br, bc;

        // Drive every input to a known value before the first edge.
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_idx           = CFG_COS;
        cfg_wdata         = '0;
        req_bus.valid     = 1'b0;
        req_bus.req_type  = REQ_LOAD;
        req_bus.src_row   = '0;
        req_bus.src_col   = '0;
        req_bus.pix_r     = '0;
        req_bus.pix_g     = '0;
        req_bus.pix_b     = '0;
        req_bus.pix_alpha = '0;
        req_bus.out_row   = '0;
        req_bus.out_col   = '0;
        rsp_bus.ready     = 1'b0;

        model_cfg = '{cos_q: COS_RESET, sin_q: SIN_RESET,
                      src_rows: ROWS_RESET, src_cols: COLS_RESET};
        gen_cfg   = model_cfg;

        // Directed part, starting from the reset settings (identity, 256 x 256).
        // Load the four store corners, white-and-black extremes among them.
        push_load(8'd0,   8'd0,   32'h0000_0000);
        push_load(8'd255, 8'd255, 32'hFFFF_FFFF);
        push_load(8'd0,   8'd255, 32'h7856_3412);
        push_load(8'd255, 8'd0,   32'h3CC3_5AA5);
        try_fetch(0, 0, 0, 0, sent);
        try_fetch(255, 255, 255, 255, sent);
        try_fetch(0, 0, 255, 255, sent);
        try_fetch(255, 255, 0, 0, sent);
        // Requests beyond the rotated box still go through the same mapping.
        try_fetch(256, 256, 0, 0, sent);
        try_fetch(0, 0, 511, 511, sent);
        try_fetch(511, 511, 511, 511, sent);
        // Hold the sender until every fetched pixel has returned.
        push_drain();
        // Size registers below range clamp up to one row and one column.
        reconfigure(16384, 0, 0, 0);
        try_fetch(0, 0, 0, 0, sent);
        try_fetch(1, 1, 1, 1, sent);
        // Size registers above range clamp down to the store size.
        reconfigure(16384, 0, 511, 300);
        try_fetch(255, 255, 255, 255, sent);
        // Unnormalized angle at the trig extremes: the box saturates.
        reconfigure(32767, -32768, 256, 2);
        repeat (3)
            try_fetch(0, 511, 0, 511, sent);
        // Quarter turns on the full store: box corners land on store corners.
        reconfigure(0, 16384, 256, 256);
        try_fetch(0, 0, 0, 0, sent);
        try_fetch(255, 255, 255, 255, sent);
        reconfigure(-16384, 0, 256, 256);
        try_fetch(0, 0, 0, 0, sent);
        try_fetch(255, 255, 255, 255, sent);
        reconfigure(0, -16384, 256, 256);
        try_fetch(0, 0, 0, 0, sent);
        try_fetch(255, 255, 255, 255, sent);

        // Random phases: pick a setting, load a small source, then mix
        // fetches with reloads and stray loads.
        while (item_count < ITEM_TARGET)
        begin
            mode   = $urandom_range(0, 7);
            rows_v = $urandom_range(1, 12);
            cols_v = $urandom_range(1, 12);
            theta  = $urandom_range(0, 3599) * 3.14159265358979 / 1800.0;
            cr     = 16384.0 * $cos(theta);
            sr_r   = 16384.0 * $sin(theta);
            cq     = (cr >= 0.0) ? $rtoi(cr + 0.5) : -$rtoi(-cr + 0.5);
            sq     = (sr_r >= 0.0) ? $rtoi(sr_r + 0.5) : -$rtoi(-sr_r + 0.5);
            case (mode)
                4:
                begin
                    quarter = $urandom_range(0, 3);
                    cq = (quarter == 0) ? 16384 : (quarter == 2) ? -16384 : 0;
                    sq = (quarter == 1) ? 16384 : (quarter == 3) ? -16384 : 0;
                end
                5:
                begin
                    cq = $urandom_range(0, 32768) - 16384;
                    sq = $urandom_range(0, 32768) - 16384;
                end
                6:
                begin
                    cq = $urandom_range(0, 65535) - 32768;
                    sq = $urandom_range(0, 65535) - 32768;
                end
                7:
                begin
                    // Large or out-of-range sizes; source only partly loaded.
                    rows_v = $urandom_range(0, 511);
                    cols_v = $urandom_range(0, 511);
                end
                default: ;
            endcase
            reconfigure(cq, sq, rows_v, cols_v);
            nr = int'(size_in_use(gen_cfg.src_rows, MAX_ROWS_DEF));
            nc = int'(size_in_use(gen_cfg.src_cols, MAX_COLS_DEF));
            if (nr * nc <= 144)
            begin
                for (int r = 0; r < nr; r++)
                    for (int c = 0; c < nc; c++)
                        push_load(SRC_POS_W'(r), SRC_POS_W'(c), $urandom());
            end
            back_map(gen_cfg, '0, '0, sr, sc, in_src, br, bc);
            steps = $urandom_range(40, 120);
            repeat (steps)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 2)
                    push_drain();
                else if (sel < 17)
                    push_load(SRC_POS_W'($urandom_range(0, nr - 1)),
                              SRC_POS_W'($urandom_range(0, nc - 1)), $urandom());
                else if (sel < 22)
                    push_load(SRC_POS_W'($urandom_range(0, 255)),
                              SRC_POS_W'($urandom_range(0, 255)), $urandom());
                else
                begin
                    if (sel < 32)
                        try_fetch(0, 511, 0, 511, sent);
                    else
                        try_fetch(0, (br < 511) ? int'(br) + 1 : 511,
                                  0, (bc < 511) ? int'(bc) + 1 : 511, sent);
                    // Fall back to a reload when every draw hit an empty entry.
                    if (!sent)
                        push_load(SRC_POS_W'($urandom_range(0, nr - 1)),
                                  SRC_POS_W'($urandom_range(0, nc - 1)), $urandom());
                end
            end
        end

        // Hold reset, then release it on a falling edge, away from the rising edge.
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait out the plan, then every fetched pixel, then a short tail.
        while (request_plan.size() != 0 || req_bus.valid)
            @(posedge clk);
        while (pixels_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (fail_count == 0)
            $display("** image_rotate_nearest: PASSED **");
        else
            $display("** image_rotate_nearest: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: advance the plan on the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_requests
        step_t head;
        logic  v_next;
        logic  we_next;
        if (rst_n)
        begin
            v_next  = 1'b0;
            we_next = 1'b0;
            if (req_bus.valid && !req_taken)
                // Hold the item until the block takes it.
                v_next = 1'b1;
            else if (gap_left > 0)
                gap_left--;
            else if (request_plan.size() != 0)
            begin
                head = request_plan[0];
                case (head.kind)
                    STEP_ITEM:
                    begin
                        req_bus.req_type  <= head.req_type;
                        req_bus.src_row   <= head.src_row;
                        req_bus.src_col   <= head.src_col;
                        req_bus.pix_r     <= head.pixel[7:0];
                        req_bus.pix_g     <= head.pixel[15:8];
                        req_bus.pix_b     <= head.pixel[23:16];
                        req_bus.pix_alpha <= head.pixel[31:24];
                        req_bus.out_row   <= head.out_row;
                        req_bus.out_col   <= head.out_col;
                        v_next   = 1'b1;
                        gap_left = idle_len();
                        void'(request_plan.pop_front());
                    end
                    STEP_REG:
                    begin
                        // The block is quiet here, so the predictor may
                        // take the new value right away.
                        cfg_idx   <= head.reg_idx;
                        cfg_wdata <= head.reg_val;
                        we_next   = 1'b1;
                        case (head.reg_idx)
                            CFG_COS:  model_cfg.cos_q    = head.reg_val;
                            CFG_SIN:  model_cfg.sin_q    = head.reg_val;
                            CFG_ROWS: model_cfg.src_rows = head.reg_val[SIZE_W-1:0];
                            CFG_COLS: model_cfg.src_cols = head.reg_val[SIZE_W-1:0];
                            default: ;
                        endcase
                        void'(request_plan.pop_front());
                    end
                    default:
                    begin
                        // Drain: wait for every result, then let the fetch
                        // pipeline settle before anything else goes out.
                        if (pixels_due.size() == 0)
                        begin
                            if (settle_count >= SETTLE_CYCLES)
                            begin
                                settle_count = 0;
                                void'(request_plan.pop_front());
                            end
                            else
                                settle_count++;
                        end
                    end
                endcase
            end
            req_bus.valid <= v_next;
            cfg_we        <= we_next;
        end
    end

    // Result side back-pressure, changed on the falling edge.
    always @(negedge clk)
    begin : drive_ready
        int n;
        if (rst_n)
        begin
            if (ready_left > 0)
                ready_left--;
            else
            begin
                n = idle_len();
                if (n == 0)
                begin
                    rsp_bus.ready <= 1'b1;
                    ready_left = $urandom_range(0, 6);
                end
                else
                begin
                    rsp_bus.ready <= 1'b0;
                    ready_left = n - 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on accepted items, check accepted results
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_channels
        rot_pixel_t        got;
        rot_pixel_t        want;
        longint            srow, scol;
        logic              in_src;
        logic [SIZE_W-1:0] br, bc;
        logic [WORD_W-1:0] word;
        cycle_count++;
        // Toggle between idling and back-to-back stretches now and then.
        if (cycle_count % 300 == 0)
            idling_on = ($urandom_range(0, 3) != 0);
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t timeout with %0d pixels outstanding", $time, pixels_due.size());
            $display("** image_rotate_nearest: FAILED **");
            $finish;
        end
        else if (rst_n)
        begin
            req_taken <= req_bus.valid && req_bus.ready;

            if (rsp_bus.valid && rsp_bus.ready)
            begin
                got.red          = rsp_bus.red;
                got.green        = rsp_bus.green;
                got.blue         = rsp_bus.blue;
                got.alpha        = rsp_bus.alpha;
                got.in_source    = rsp_bus.in_source;
                got.rotated_rows = rsp_bus.rotated_rows;
                got.rotated_cols = rsp_bus.rotated_cols;
                if (pixels_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t unexpected pixel rgba %h %h %h %h in %b box %0d x %0d",
                                 $time, got.red, got.green, got.blue, got.alpha,
                                 got.in_source, got.rotated_rows, got.rotated_cols);
                end
                else
                begin
                    want = pixels_due.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display({"%0t pixel mismatch: expected rgba %h %h %h %h in %b",
                                      " box %0d x %0d, got rgba %h %h %h %h in %b box %0d x %0d"},
                                     $time, want.red, want.green, want.blue, want.alpha,
                                     want.in_source, want.rotated_rows, want.rotated_cols,
                                     got.red, got.green, got.blue, got.alpha,
                                     got.in_source, got.rotated_rows, got.rotated_cols);
                    end
                end
            end

            if (req_bus.valid && req_bus.ready)
            begin
                if (req_bus.req_type == REQ_LOAD)
                    source_image[{req_bus.src_row, req_bus.src_col}] =
                        {req_bus.pix_alpha, req_bus.pix_b, req_bus.pix_g, req_bus.pix_r};
                else
                begin
                    back_map(model_cfg, req_bus.out_row, req_bus.out_col,
                             srow, scol, in_src, br, bc);
                    want.rotated_rows = br;
                    want.rotated_cols = bc;
                    if (in_src)
                    begin
                        word = source_image[int'(srow) * MAX_COLS_DEF + int'(scol)];
                        want.red       = word[7:0];
                        want.green     = word[15:8];
                        want.blue      = word[23:16];
                        want.alpha     = word[31:24];
                        want.in_source = 1'b1;
                    end
                    else
                    begin
                        // Outside the source: white, fully transparent.
                        want.red       = PIX_FULL;
                        want.green     = PIX_FULL;
                        want.blue      = PIX_FULL;
                        want.alpha     = PIX_NONE;
                        want.in_source = 1'b0;
                    end
                    pixels_due.push_back(want);
                end
            end
        end
    end

endmodule

@@ image_rotate_nearest.f @@
rtl/core/imgrot_pkg.sv
rtl/core/imgrot_if.sv
rtl/core/imgrot_ctrl.sv
rtl/core/imgrot_dp.sv
rtl/core/image_rotate_nearest.sv
tb/sv/image_rotate_nearest_tb.sv
